@@ hw/rtl/cbpg_pkg.sv @@
// Shared constants, types and the Bernstein weight function of the cubic Bezier point generator.
`timescale 1ns / 1ps

package cbpg_pkg;

  // Points per curve; a power of two, so the division by STEPS^3 is a right shift
  localparam int STEPS   = 64;
  localparam int K_W     = $clog2(STEPS);
  localparam int COORD_W = 16;
  localparam int SHIFT   = 3 * K_W;        // log2(STEPS^3)
  localparam int WGT_W   = SHIFT + 1;      // holds STEPS^3 itself at k = 0
  localparam int PROD_W  = COORD_W + WGT_W;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int SUM_W   = PROD_W + 2;

  typedef logic [K_W-1:0]              step_t;
  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic [WGT_W-1:0]            wgt_t;
  typedef logic [3:0][COORD_W-1:0]     quad_t;     // control points, index 0 = P0
  typedef logic [3:0][WGT_W-1:0]       weights_t;  // weights, index 0 goes with P0

  localparam step_t K_LAST = step_t'(STEPS - 1);

  // Valid and end-of-curve flag that travel down the pipeline with each point
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  // Integer Bernstein weights for t = k/STEPS, all scaled by STEPS^3
  function automatic weights_t bern_weights(step_t k);
    int unsigned kk;
    int unsigned u;
    weights_t    w;
    kk   = 32'(k);
    u    = 32'(STEPS) - kk;
    w[0] = wgt_t'(u * u * u);
    w[1] = wgt_t'(3 * kk * u * u);
    w[2] = wgt_t'(3 * kk * kk * u);
    w[3] = wgt_t'(kk * kk * kk);
    return w;
  endfunction

endpackage

@@ hw/rtl/cbpg_if.sv @@
// Request channel interfaces: control-point input and curve-point output.
`timescale 1ns / 1ps

interface cbpg_in_if;
  logic              valid;
  logic              ready;
  cbpg_pkg::coord_t  p0_x;
  cbpg_pkg::coord_t  p0_y;
  cbpg_pkg::coord_t  p1_x;
  cbpg_pkg::coord_t  p1_y;
  cbpg_pkg::coord_t  p2_x;
  cbpg_pkg::coord_t  p2_y;
  cbpg_pkg::coord_t  p3_x;
  cbpg_pkg::coord_t  p3_y;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

interface cbpg_out_if;
  logic              valid;
  logic              ready;
  cbpg_pkg::coord_t  point_x;
  cbpg_pkg::coord_t  point_y;
  logic              last_point;

  modport source (
    output valid, point_x, point_y, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, last_point,
    output ready
  );
endinterface

@@ hw/rtl/cubic_bezier_point_generator.sv @@
// Top level of the cubic Bezier point generator: issue counter, weight stage and pipeline control.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------------
//   in_ch    | in  | valid / ready      | p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
//   out_ch   | out | valid / ready      | point_x point_y last_point
//
// Each request of four control points yields STEPS (64) points, one per cycle while out_ch
// is not stalled; the next request is taken in the cycle the last point issues. Each point
// passes the issue counter, the weight stage and the three register stages of an axis.
// Reset (rst_n low, synchronous) empties the pipeline and stops the counter.
// A stall on out_ch freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps

module cubic_bezier_point_generator (
  input  logic        clk,
  input  logic        rst_n,
  cbpg_in_if.sink     in_ch,
  cbpg_out_if.source  out_ch
);

  logic                en;
  logic                accept;
  logic                busy_r;
  logic                busy_nxt;
  cbpg_pkg::step_t     k_r;
  cbpg_pkg::step_t     k_nxt;
  cbpg_pkg::quad_t     itx_r;
  cbpg_pkg::quad_t     ity_r;
  cbpg_pkg::tag_t      tag_a;
  cbpg_pkg::tag_t      tag_b_r;
  cbpg_pkg::tag_t      tag_c_r;
  cbpg_pkg::tag_t      tag_d_r;
  cbpg_pkg::tag_t      tag_o_r;
  cbpg_pkg::weights_t  wgt_b_r;
  cbpg_pkg::quad_t     ptx_b_r;
  cbpg_pkg::quad_t     pty_b_r;

  // Whole pipeline moves unless a finished point is held up
  assign en = !tag_o_r.valid || out_ch.ready;

  // New request taken when idle or as the last point of the current one issues
  assign in_ch.ready = !busy_r || (en && (k_r == cbpg_pkg::K_LAST));
  assign accept      = in_ch.valid && in_ch.ready;

  // Step counter
  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (busy_r && en) begin
      if (k_r == cbpg_pkg::K_LAST) begin
        busy_nxt = 1'b0;
        k_nxt    = '0;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  // Control points of the request being issued
  always_ff @(posedge clk) begin
    if (accept) begin
      itx_r <= {in_ch.p3_x, in_ch.p2_x, in_ch.p1_x, in_ch.p0_x};
      ity_r <= {in_ch.p3_y, in_ch.p2_y, in_ch.p1_y, in_ch.p0_y};
    end
  end

  assign tag_a.valid = busy_r;
  assign tag_a.last  = busy_r && (k_r == cbpg_pkg::K_LAST);

  // Stage valid/last bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
      tag_c_r <= '0;
      tag_d_r <= '0;
      tag_o_r <= '0;
    end else if (en) begin
      tag_b_r <= tag_a;
      tag_c_r <= tag_b_r;
      tag_d_r <= tag_c_r;
      tag_o_r <= tag_d_r;
    end
  end

  // Weight lookup stage; points are copied so a new request can load behind it
  always_ff @(posedge clk) begin
    if (en) begin
      wgt_b_r <= cbpg_pkg::bern_weights(k_r);
      ptx_b_r <= itx_r;
      pty_b_r <= ity_r;
    end
  end

  cbpg_axis u_axis_x (
    .clk     (clk),
    .en      (en),
    .pts     (ptx_b_r),
    .wgt     (wgt_b_r),
    .point_r (out_ch.point_x)
  );

  cbpg_axis u_axis_y (
    .clk     (clk),
    .en      (en),
    .pts     (pty_b_r),
    .wgt     (wgt_b_r),
    .point_r (out_ch.point_y)
  );

  assign out_ch.valid      = tag_o_r.valid;
  assign out_ch.last_point = tag_o_r.last;

endmodule

@@ hw/rtl/cbpg_axis.sv @@
// One coordinate axis: weighted products, adder tree and scaling, three register stages.
`timescale 1ns / 1ps

module cbpg_axis (
  input  logic                clk,
  input  logic                en,
  input  cbpg_pkg::quad_t     pts,
  input  cbpg_pkg::weights_t  wgt,
  output cbpg_pkg::coord_t    point_r
);

  logic [3:0][cbpg_pkg::PROD_W-1:0] prod_r;
  logic [3:0][cbpg_pkg::PROD_W-1:0] prod_nxt;
  logic [1:0][cbpg_pkg::PAIR_W-1:0] pair_r;
  logic [1:0][cbpg_pkg::PAIR_W-1:0] pair_nxt;
  logic [cbpg_pkg::SUM_W-1:0]       sum;
  cbpg_pkg::coord_t                 point_nxt;

  // Four 16 x 19 products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = cbpg_pkg::PROD_W'(pts[i]) * cbpg_pkg::PROD_W'(wgt[i]);
    end
  end

  // First adder level
  assign pair_nxt[0] = cbpg_pkg::PAIR_W'(prod_r[0]) + cbpg_pkg::PAIR_W'(prod_r[1]);
  assign pair_nxt[1] = cbpg_pkg::PAIR_W'(prod_r[2]) + cbpg_pkg::PAIR_W'(prod_r[3]);

  // Final add, then floor-divide by STEPS^3 (weights sum to STEPS^3, so it fits 16 bits)
  assign sum       = cbpg_pkg::SUM_W'(pair_r[0]) + cbpg_pkg::SUM_W'(pair_r[1]);
  assign point_nxt = sum[cbpg_pkg::SHIFT +: cbpg_pkg::COORD_W];

  // Data registers advance together with the stage valid bits in the top level
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      pair_r  <= pair_nxt;
      point_r <= point_nxt;
    end
  end

endmodule

@@ hw/rtl/cbpg_chk.sv @@
// Port-level checks of the cubic Bezier point generator, bound to the top level.
`timescale 1ns / 1ps

module cbpg_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input cbpg_pkg::coord_t  out_x,
  input cbpg_pkg::coord_t  out_y,
  input logic              out_last
);

  // Held point keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_last))
    else $error("stalled point changed");

  // A taken request closes the input, so no second request follows it at once
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken right after the first");

  // Pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Two end-of-curve points never follow each other
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !(out_valid && out_last))
    else $error("back-to-back end-of-curve points");

endmodule

bind cubic_bezier_point_generator cbpg_chk u_cbpg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.point_x),
  .out_y     (out_ch.point_y),
  .out_last  (out_ch.last_point)
);
